/* rtl/hpq_pkg.sv */
// ----------------------------------------------------------------------------
// Heap priority queue package
// Operation and status codes shared by the interfaces, the queue and its checker.
// ----------------------------------------------------------------------------
package hpq_pkg;

    localparam int OP_W     = 2;
    localparam int FIELD_W  = 32;
    localparam int SLOT_W   = 10;
    localparam int COUNT_W  = 11;
    localparam int STATUS_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_POP    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CHANGE = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_BAD_IDX = 2'd3
    } t_status;

endpackage

/* rtl/hpq_if.sv */
// ----------------------------------------------------------------------------
// Heap priority queue channels
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface hpq_req_if
    import hpq_pkg::*;
    ();
    logic               valid;
    logic               ready;
    t_op                operation;
    logic [FIELD_W-1:0] key_value;
    logic [SLOT_W-1:0]  slot_index;

    modport source (output valid, output operation, output key_value,
                    output slot_index, input ready);
    modport sink   (input valid, input operation, input key_value,
                    input slot_index, output ready);
endinterface

interface hpq_rsp_if
    import hpq_pkg::*;
    ();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] popped_key;
    logic [FIELD_W-1:0] top_key;
    logic [COUNT_W-1:0] entry_count;
    t_status            status;

    modport source (output valid, output popped_key, output top_key,
                    output entry_count, output status, input ready);
    modport sink   (input valid, input popped_key, input top_key,
                    input entry_count, input status, output ready);
endinterface

/* rtl/max_heap_priority_queue_unit.sv */
// ----------------------------------------------------------------------------
// Max-heap priority queue
// Binary max-heap held in one synchronous memory, one operation per item.
//
//   Channel  Direction  Carries
//   i_req    in         operation, key_value, slot_index
//   o_rsp    out        popped_key, top_key, entry_count, status
//
// Each level of the sift loop going up needs one read of the single memory
// read port, and each level going down needs one or two reads.
// Reset clears the state, the count, the first flag and the output valid; the memory needs no clearing.
// A new item is taken while the previous result waits in the output register.
// ----------------------------------------------------------------------------
module max_heap_priority_queue_unit
    import hpq_pkg::*;
#(
    parameter int CAPACITY  = 1024,
    parameter int KEY_WIDTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hpq_req_if.sink    i_req,
    hpq_rsp_if.source  o_rsp
);

    localparam int IW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int CHW = IW + 2;

    typedef enum logic [3:0] {
        S_IDLE, S_POP_ROOT, S_LOAD, S_CHG_OLD, S_UP_CHK, S_UP_CMP,
        S_DOWN_CHK, S_DOWN_L, S_DOWN_R, S_TOP_RD, S_RESP
    } t_state;

    logic [KEY_WIDTH-1:0] r_mem [CAPACITY];
    logic [KEY_WIDTH-1:0] r_rdata;

    t_state               r_state,  n_state;
    logic [IW-1:0]        r_pos,    n_pos;
    logic [KEY_WIDTH-1:0] r_key,    n_key;
    logic [CW-1:0]        r_count,  n_count;
    logic [KEY_WIDTH-1:0] r_popped, n_popped;
    t_status              r_status, n_status;
    logic                 r_first,  n_first;
    logic [IW-1:0]        r_bidx,   n_bidx;
    logic [KEY_WIDTH-1:0] r_bval,   n_bval;
    logic                 r_out_valid, n_out_valid;
    logic [FIELD_W-1:0]   r_out_popped, n_out_popped;
    logic [FIELD_W-1:0]   r_out_top,    n_out_top;
    logic [COUNT_W-1:0]   r_out_count,  n_out_count;
    t_status              r_out_status, n_out_status;

    logic                 we, re;
    logic [IW-1:0]        wa, ra;
    logic [KEY_WIDTH-1:0] wd;

    logic                 acc;
    logic [CHW-1:0]       lc, rc;
    logic                 lc_in, rc_in;
    logic [IW-1:0]        parent;
    logic [IW-1:0]        cand_idx;
    logic [KEY_WIDTH-1:0] cand_val;
    logic                 do_move;
    logic                 bad_idx;

    assign i_req.ready = (r_state == S_IDLE);
    assign acc         = i_req.valid && (r_state == S_IDLE);

    assign lc      = (CHW'(r_pos) << 1) + CHW'(1);
    assign rc      = lc + CHW'(1);
    assign lc_in   = lc < CHW'(r_count);
    assign rc_in   = rc < CHW'(r_count);
    assign parent  = (r_pos - IW'(1)) >> 1;
    assign bad_idx = 32'(i_req.slot_index) >= 32'(r_count);

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.popped_key  = r_out_popped;
    assign o_rsp.top_key     = r_out_top;
    assign o_rsp.entry_count = r_out_count;
    assign o_rsp.status      = r_out_status;

    always_comb begin
        n_state      = r_state;
        n_pos        = r_pos;
        n_key        = r_key;
        n_count      = r_count;
        n_popped     = r_popped;
        n_status     = r_status;
        n_first      = r_first;
        n_bidx       = r_bidx;
        n_bval       = r_bval;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_popped = r_out_popped;
        n_out_top    = r_out_top;
        n_out_count  = r_out_count;
        n_out_status = r_out_status;
        we           = 1'b0;
        re           = 1'b0;
        wa           = r_pos;
        ra           = '0;
        wd           = r_key;
        cand_idx     = r_pos;
        cand_val     = r_key;
        do_move      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_key    = KEY_WIDTH'(i_req.key_value);
                    n_status = ST_OK;
                    n_popped = '0;
                    n_first  = 1'b0;
                    case (i_req.operation)
                        OP_INSERT: begin
                            if (r_count >= CW'(CAPACITY)) begin
                                n_status = ST_FULL;
                                n_state  = S_TOP_RD;
                            end else begin
                                n_pos   = r_count[IW-1:0];
                                n_count = r_count + CW'(1);
                                n_state = S_UP_CHK;
                            end
                        end
                        OP_POP: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_TOP_RD;
                            end else begin
                                re      = 1'b1;
                                ra      = '0;
                                n_pos   = '0;
                                n_state = S_POP_ROOT;
                            end
                        end
                        OP_REMOVE: begin
                            if (bad_idx) begin
                                n_status = ST_BAD_IDX;
                                n_state  = S_TOP_RD;
                            end else begin
                                re      = 1'b1;
                                ra      = IW'(r_count - CW'(1));
                                n_count = r_count - CW'(1);
                                n_pos   = IW'(i_req.slot_index);
                                n_first = 1'b1;
                                n_state = S_LOAD;
                            end
                        end
                        OP_CHANGE: begin
                            if (bad_idx) begin
                                n_status = ST_BAD_IDX;
                                n_state  = S_TOP_RD;
                            end else begin
                                re      = 1'b1;
                                ra      = IW'(i_req.slot_index);
                                n_pos   = IW'(i_req.slot_index);
                                n_state = S_CHG_OLD;
                            end
                        end
                        default: n_state = S_TOP_RD;
                    endcase
                end
            end
            S_POP_ROOT: begin
                n_popped = r_rdata;
                re       = 1'b1;
                ra       = IW'(r_count - CW'(1));
                n_count  = r_count - CW'(1);
                n_state  = S_LOAD;
            end
            S_LOAD: begin
                n_key = r_rdata;
                if (r_first && r_pos != '0 && CW'(r_pos) < r_count) begin
                    n_state = S_UP_CHK;
                end else begin
                    n_first = 1'b0;
                    n_state = S_DOWN_CHK;
                end
            end
            S_CHG_OLD: begin
                if (r_key > r_rdata) begin
                    n_state = S_UP_CHK;
                end else begin
                    n_state = S_DOWN_CHK;
                end
            end
            S_UP_CHK: begin
                if (r_pos == '0) begin
                    we      = 1'b1;
                    n_state = S_TOP_RD;
                end else begin
                    re      = 1'b1;
                    ra      = parent;
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                n_first = 1'b0;
                if (r_key > r_rdata) begin
                    we      = 1'b1;
                    wd      = r_rdata;
                    n_pos   = parent;
                    n_state = S_UP_CHK;
                end else if (r_first) begin
                    n_state = S_DOWN_CHK;
                end else begin
                    we      = 1'b1;
                    n_state = S_TOP_RD;
                end
            end
            S_DOWN_CHK: begin
                if (!lc_in) begin
                    we      = 1'b1;
                    n_state = S_TOP_RD;
                end else begin
                    re      = 1'b1;
                    ra      = lc[IW-1:0];
                    n_state = S_DOWN_L;
                end
            end
            S_DOWN_L: begin
                if (r_key < r_rdata) begin
                    cand_idx = lc[IW-1:0];
                    cand_val = r_rdata;
                end
                if (rc_in) begin
                    n_bidx  = cand_idx;
                    n_bval  = cand_val;
                    re      = 1'b1;
                    ra      = rc[IW-1:0];
                    n_state = S_DOWN_R;
                end else begin
                    do_move = 1'b1;
                end
            end
            S_DOWN_R: begin
                cand_idx = r_bidx;
                cand_val = r_bval;
                if (r_bval < r_rdata) begin
                    cand_idx = rc[IW-1:0];
                    cand_val = r_rdata;
                end
                do_move = 1'b1;
            end
            S_TOP_RD: begin
                re      = 1'b1;
                ra      = '0;
                n_state = S_RESP;
            end
            S_RESP: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_popped = FIELD_W'(r_popped);
                    n_out_top    = (r_count != '0) ? FIELD_W'(r_rdata) : '0;
                    n_out_count  = COUNT_W'(r_count);
                    n_out_status = r_status;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (do_move) begin
            we = 1'b1;
            if (cand_idx == r_pos) begin
                n_state = S_TOP_RD;
            end else begin
                wd      = cand_val;
                n_pos   = cand_idx;
                n_state = S_DOWN_CHK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        if (re) begin
            r_rdata <= r_mem[ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_first     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_first     <= n_first;
            r_out_valid <= n_out_valid;
        end
        r_pos        <= n_pos;
        r_key        <= n_key;
        r_popped     <= n_popped;
        r_status     <= n_status;
        r_bidx       <= n_bidx;
        r_bval       <= n_bval;
        r_out_popped <= n_out_popped;
        r_out_top    <= n_out_top;
        r_out_count  <= n_out_count;
        r_out_status <= n_out_status;
    end

endmodule

/* rtl/hpq_checker.sv */
// ----------------------------------------------------------------------------
// Heap priority queue checker
// Port-level properties of the queue, bound to the top level.
// ----------------------------------------------------------------------------
module hpq_checker
    import hpq_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [FIELD_W-1:0] i_popped_key,
    input logic [FIELD_W-1:0] i_top_key,
    input logic [COUNT_W-1:0] i_entry_count,
    input t_status            i_status
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("Response item dropped while stalled.");

    a_fail_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != ST_OK |-> i_popped_key == '0)
        else $error("Failed operation returned a popped key.");

    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_entry_count == '0 |-> i_top_key == '0)
        else $error("Empty heap reported a top key.");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_EMPTY |-> i_entry_count == '0)
        else $error("Empty status with a non-zero count.");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !$rose(i_out_valid))
        else $error("Response appeared one cycle after the request.");

endmodule

bind max_heap_priority_queue_unit hpq_checker u_hpq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_req.valid),
    .i_in_ready    (i_req.ready),
    .i_out_valid   (o_rsp.valid),
    .i_out_ready   (o_rsp.ready),
    .i_popped_key  (o_rsp.popped_key),
    .i_top_key     (o_rsp.top_key),
    .i_entry_count (o_rsp.entry_count),
    .i_status      (o_rsp.status)
);

/* tb/tb_max_heap_priority_queue_unit.sv */
// ----------------------------------------------------------------------------
// Max-heap priority queue testbench
// Drives operation items through the request channel, predicts every response
// with a behavioural heap of its own, and compares every field of each response.
// ----------------------------------------------------------------------------
module tb_max_heap_priority_queue_unit;
    import hpq_pkg::*;

    localparam int CAP       = 1024;
    localparam int N_RANDOM  = 180;
    localparam int MAX_CYCLE = 2000000;

    typedef struct packed {
        logic [FIELD_W-1:0] popped_key;
        logic [FIELD_W-1:0] top_key;
        logic [COUNT_W-1:0] entry_count;
        t_status            status;
    } t_result;

    typedef struct {
        t_op                op;
        logic [FIELD_W-1:0] key;
        logic [SLOT_W-1:0]  slot;
        bit                 has_exp;
        t_result            exp;
    } t_row;

    localparam t_result NO_EXP = '{32'h0, 32'h0, 11'd0, ST_OK};

    logic i_clk;
    logic i_rst_n;

    hpq_req_if req ();
    hpq_rsp_if rsp ();

    max_heap_priority_queue_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req.sink),
        .o_rsp   (rsp.source)
    );

    logic [FIELD_W-1:0] heap_keys [CAP];
    int unsigned        heap_size;
    t_result            pending_results [$];
    int                 n_errors;
    int                 n_cycles;
    bit                 stall_long;
    bit                 no_idle;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic void swap_keys(int unsigned a, int unsigned b);
        logic [FIELD_W-1:0] t;
        t            = heap_keys[a];
        heap_keys[a] = heap_keys[b];
        heap_keys[b] = t;
    endfunction

    function automatic void bubble_up(int unsigned pos);
        int unsigned up;
        while (pos > 0 && pos < heap_size) begin
            up = (pos - 1) / 2;
            if (heap_keys[pos] > heap_keys[up]) begin
                swap_keys(pos, up);
                pos = up;
            end else begin
                break;
            end
        end
    endfunction

    function automatic void bubble_down(int unsigned pos);
        int unsigned best;
        while (pos < heap_size) begin
            best = pos;
            if (2 * pos + 1 < heap_size && heap_keys[best] < heap_keys[2 * pos + 1])
                best = 2 * pos + 1;
            if (2 * pos + 2 < heap_size && heap_keys[best] < heap_keys[2 * pos + 2])
                best = 2 * pos + 2;
            if (best == pos)
                break;
            swap_keys(pos, best);
            pos = best;
        end
    endfunction

    function automatic t_result apply_heap_op(t_op op, logic [FIELD_W-1:0] key,
                                              logic [SLOT_W-1:0] slot);
        t_result            r;
        logic [FIELD_W-1:0] old;
        r.popped_key = '0;
        r.status     = ST_OK;
        case (op)
            OP_INSERT: begin
                if (heap_size >= CAP) begin
                    r.status = ST_FULL;
                end else begin
                    heap_keys[heap_size] = key;
                    heap_size++;
                    bubble_up(heap_size - 1);
                end
            end
            OP_POP: begin
                if (heap_size == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.popped_key = heap_keys[0];
                    heap_size--;
                    heap_keys[0] = heap_keys[heap_size];
                    bubble_down(0);
                end
            end
            OP_REMOVE: begin
                if (slot >= heap_size) begin
                    r.status = ST_BAD_IDX;
                end else begin
                    heap_size--;
                    heap_keys[slot] = heap_keys[heap_size];
                    if (slot > 0 && slot < heap_size &&
                        heap_keys[slot] > heap_keys[(slot - 1) / 2])
                        bubble_up(slot);
                    else
                        bubble_down(slot);
                end
            end
            default: begin
                if (slot >= heap_size) begin
                    r.status = ST_BAD_IDX;
                end else begin
                    old             = heap_keys[slot];
                    heap_keys[slot] = key;
                    if (key > old)
                        bubble_up(slot);
                    else
                        bubble_down(slot);
                end
            end
        endcase
        r.top_key     = heap_size != 0 ? heap_keys[0] : '0;
        r.entry_count = COUNT_W'(heap_size);
        return r;
    endfunction

    task automatic send_item(t_op op, logic [FIELD_W-1:0] key, logic [SLOT_W-1:0] slot);
        t_result exp_r;
        while (!no_idle && $urandom_range(99) < 11) begin
            req.valid <= 1'b0;
            @(posedge i_clk);
        end
        req.valid      <= 1'b1;
        req.operation  <= op;
        req.key_value  <= key;
        req.slot_index <= slot;
        exp_r = apply_heap_op(op, key, slot);
        pending_results.insert(pending_results.size(), exp_r);
        @(posedge i_clk);
        while (!req.ready)
            @(posedge i_clk);
    endtask

    function automatic logic [FIELD_W-1:0] rand_key();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            2:       return FIELD_W'($urandom_range(15));
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [SLOT_W-1:0] rand_slot();
        if (heap_size != 0 && $urandom_range(9) < 8)
            return SLOT_W'($urandom_range(heap_size - 1));
        return SLOT_W'($urandom());
    endfunction

    task automatic wait_drained();
        req.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    // Response checker, with random back-pressure and one long hold-off.
    always @(posedge i_clk) begin
        t_result got;
        t_result exp;
        if (i_rst_n && rsp.valid && rsp.ready) begin
            got = '{rsp.popped_key, rsp.top_key, rsp.entry_count, rsp.status};
            if (pending_results.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected response %p", got);
            end else begin
                exp = pending_results.pop_front();
                if (got !== exp) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("mismatch: expected %p got %p", exp, got);
                end
            end
        end
        rsp.ready <= i_rst_n && !stall_long && (no_idle || $urandom_range(99) >= 11);
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > MAX_CYCLE) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        int   stall_count;
        stall_long  = 1'b0;
        stall_count = 0;
        wait (n_cycles == 3000);
        stall_long = 1'b1;
        while (stall_count < 600) begin
            @(posedge i_clk);
            stall_count++;
        end
        stall_long = 1'b0;
    end

    initial begin
        t_row    rows [$];
        t_result got_top;
        int      k;
        int      n_ok;
        heap_size      = 0;
        n_errors       = 0;
        n_cycles       = 0;
        no_idle        = 1'b0;
        i_rst_n        = 1'b0;
        req.valid      = 1'b0;
        req.operation  = OP_INSERT;
        req.key_value  = '0;
        req.slot_index = '0;
        rsp.ready      = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty pop, bad indexes, extremes, ties, removal at root and at the last slot.
        rows = '{
            '{OP_POP,    32'h0,        10'd0,   1, '{32'h0, 32'h0, 11'd0, ST_EMPTY}},
            '{OP_REMOVE, 32'h0,        10'd0,   1, '{32'h0, 32'h0, 11'd0, ST_BAD_IDX}},
            '{OP_CHANGE, 32'h5,        10'd1023,1, '{32'h0, 32'h0, 11'd0, ST_BAD_IDX}},
            '{OP_INSERT, 32'h0,        10'd0,   1, '{32'h0, 32'h0, 11'd1, ST_OK}},
            '{OP_INSERT, 32'hFFFFFFFF, 10'd0,   1, '{32'h0, 32'hFFFFFFFF, 11'd2, ST_OK}},
            '{OP_INSERT, 32'h7,        10'h3FF, 0, NO_EXP},
            '{OP_INSERT, 32'h7,        10'd0,   0, NO_EXP},
            '{OP_INSERT, 32'hAAAAAAAA, 10'd0,   0, NO_EXP},
            '{OP_INSERT, 32'h55555555, 10'd0,   0, NO_EXP},
            '{OP_REMOVE, 32'h0,        10'd5,   0, NO_EXP},
            '{OP_REMOVE, 32'h0,        10'd0,   0, NO_EXP},
            '{OP_CHANGE, 32'hFFFFFFFF, 10'd3,   0, NO_EXP},
            '{OP_CHANGE, 32'h0,        10'd0,   0, NO_EXP},
            '{OP_REMOVE, 32'h0,        10'd2,   0, NO_EXP},
            '{OP_CHANGE, 32'h1,        10'd900, 0, NO_EXP},
            '{OP_POP,    32'h0,        10'd0,   0, NO_EXP},
            '{OP_POP,    32'h0,        10'd0,   0, NO_EXP},
            '{OP_POP,    32'h0,        10'd0,   0, NO_EXP},
            '{OP_POP,    32'h0,        10'd0,   0, NO_EXP},
            '{OP_POP,    32'h0,        10'd0,   1, '{32'h0, 32'h0, 11'd0, ST_EMPTY}}
        };
        foreach (rows[i]) begin
            send_item(rows[i].op, rows[i].key, rows[i].slot);
            got_top = pending_results[pending_results.size() - 1];
            if (rows[i].has_exp && got_top !== rows[i].exp) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("row %0d: table %p model %p", i, rows[i].exp, got_top);
            end
        end
        wait_drained();

        // Fill to capacity, with a stretch without idling, then hit full.
        no_idle = 1'b1;
        while (heap_size < CAP)
            send_item(OP_INSERT, rand_key(), '0);
        no_idle = 1'b0;
        send_item(OP_INSERT, '1, '0);
        for (k = 0; k < 20; k++)
            send_item(t_op'(OP_REMOVE + $urandom_range(1)), rand_key(), rand_slot());
        send_item(OP_INSERT, 32'h1234, '0);
        send_item(OP_INSERT, 32'h1234, '0);
        wait_drained();

        for (n_ok = 0; n_ok < N_RANDOM; n_ok++) begin
            k = $urandom_range(99);
            if (k < 40)
                send_item(OP_INSERT, rand_key(), rand_slot());
            else if (k < 60)
                send_item(OP_POP, rand_key(), rand_slot());
            else if (k < 80)
                send_item(OP_REMOVE, rand_key(), rand_slot());
            else
                send_item(OP_CHANGE, rand_key(), rand_slot());
            if (n_ok == 90)
                wait_drained();
        end

        wait_drained();
        repeat (100) @(posedge i_clk);
        if (n_errors == 0 && pending_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
